[src/esc_pkg.sv]
`timescale 1ns / 1ps

package esc_pkg;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_BACK,
        S_SUB,
        S_FIX,
        S_STORE,
        S_MONTH,
        S_OUT
    } t_state;

    // Which constant division is in flight
    typedef enum logic [2:0] {
        DIV_SEC,
        DIV_MIN,
        DIV_HR,
        DIV_PER,
        DIV_YEAR
    } t_div;

    typedef struct packed {
        logic load;
        logic mul;
        logic back;
        logic sub;
        logic fix;
        logic store;
        logic mstep;
        logic out_load;
        t_div div;
    } t_cmd;

    typedef struct packed {
        logic more;
        logic out_free;
    } t_stat;

    localparam int unsigned DIVISOR_W = 11;

    localparam logic [63:0] TWO_POW_32 = 64'd1 << 32;

    // floor(2^32 / d): the estimate is low by at most one
    localparam logic [31:0] RECIP_60   = 32'(TWO_POW_32 / 60);
    localparam logic [31:0] RECIP_24   = 32'(TWO_POW_32 / 24);
    localparam logic [31:0] RECIP_1461 = 32'(TWO_POW_32 / 1461);
    localparam logic [31:0] RECIP_365  = 32'(TWO_POW_32 / 365);

    localparam logic [15:0] DAYS_1968_TO_1970 = 16'd731;
    localparam logic [10:0] DAYS_TO_MARCH     = 11'd60;
    localparam logic [10:0] DAYS_PER_YEAR     = 11'd365;
    localparam logic [7:0]  BASE_YEAR         = 8'd68;
    localparam logic [3:0]  MONTH_INIT        = 4'd12;
    localparam logic [8:0]  START_INIT        = 9'd366;

    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    function automatic logic [31:0] div_recip(input t_div sel);
        logic [31:0] val;
        case (sel)
            DIV_SEC:  val = RECIP_60;
            DIV_MIN:  val = RECIP_60;
            DIV_HR:   val = RECIP_24;
            DIV_PER:  val = RECIP_1461;
            DIV_YEAR: val = RECIP_365;
            default:  val = RECIP_60;
        endcase
        return val;
    endfunction

    function automatic logic [DIVISOR_W-1:0] div_value(input t_div sel);
        logic [DIVISOR_W-1:0] val;
        case (sel)
            DIV_SEC:  val = 11'd60;
            DIV_MIN:  val = 11'd60;
            DIV_HR:   val = 11'd24;
            DIV_PER:  val = 11'd1461;
            DIV_YEAR: val = DAYS_PER_YEAR;
            default:  val = 11'd60;
        endcase
        return val;
    endfunction

endpackage

[src/epoch_seconds_to_calendar.sv]
`timescale 1ns / 1ps

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// second, minute, hour, day of month (1-31), zero-based month and year minus
// 1900. Every input value is legal; the leap rule is "every fourth year", so
// dates are exact through 2099 and run one day behind from 2100-03-01 on.
// One request is taken at a time: o_ready is high only while the block is
// idle. A request passes through five constant divisions (by 60, 60, 24,
// 1461 and 365) that share one 32x32 multiplier, each as reciprocal
// estimate, back-multiply, subtract, one-step correction and store, then a
// month search that steps back one month per cycle from December (one to
// twelve steps), and then a load of the output register, which waits while
// that register still holds an unaccepted result. The finished result sits
// in that output register, so the next request is accepted while it waits
// for i_ready.
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_index,
    output logic [7:0]  o_years_since_1900
);
    import esc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequence the divisions and the month walk
    esc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    // shared multiplier, partial results, month table and output register
    esc_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_epoch_seconds    (i_epoch_seconds),
        .i_ready            (i_ready),
        .o_stat             (stat),
        .o_valid            (o_valid),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_day_of_month     (o_day_of_month),
        .o_month_index      (o_month_index),
        .o_years_since_1900 (o_years_since_1900)
    );

endmodule

[src/esc_ctrl.sv]
`timescale 1ns / 1ps

module esc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  esc_pkg::t_stat i_stat,
    output logic           o_ready,
    output esc_pkg::t_cmd  o_cmd
);
    import esc_pkg::*;

    t_state r_state, n_state;
    t_div   r_div, n_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_div   <= DIV_SEC;
        end else begin
            r_state <= n_state;
            r_div   <= n_div;
        end
    end

    always_comb begin
        n_state = r_state;
        n_div   = r_div;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.div = r_div;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_MUL;
                    n_div   = DIV_SEC;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_BACK;
            end
            S_BACK: begin
                o_cmd.back = 1'b1;
                n_state    = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_div == DIV_YEAR) begin
                    n_state = S_MONTH;
                end else begin
                    n_state = S_MUL;
                    n_div   = t_div'(r_div + 3'd1);
                end
            end
            S_MONTH: begin
                // walk back one month per cycle until the start fits
                o_cmd.mstep = i_stat.more;
                if (!i_stat.more) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.out_load = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[src/esc_dpath.sv]
`timescale 1ns / 1ps

module esc_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  esc_pkg::t_cmd                i_cmd,
    input  logic [31:0]                  i_epoch_seconds,
    input  logic                         i_ready,
    output esc_pkg::t_stat               o_stat,
    output logic                         o_valid,
    output logic [5:0]                   o_second_of_minute,
    output logic [5:0]                   o_minute_of_hour,
    output logic [4:0]                   o_hour_of_day,
    output logic [4:0]                   o_day_of_month,
    output logic [3:0]                   o_month_index,
    output logic [7:0]                   o_years_since_1900
);
    import esc_pkg::*;

    // shared divider datapath
    logic [31:0] r_num;
    logic [63:0] r_prod;
    logic [31:0] r_quo;
    logic [31:0] r_rem;

    // partial results
    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [4:0]  r_hr;
    logic [15:0] r_d68;
    logic [10:0] r_prem;
    logic [7:0]  r_year;
    logic        r_leap;
    logic [8:0]  r_doy;
    logic [3:0]  r_m;
    logic [8:0]  r_start;

    // output stage
    logic        r_out_valid;
    logic [5:0]  r_o_sec;
    logic [5:0]  r_o_min;
    logic [4:0]  r_o_hr;
    logic [4:0]  r_o_day;
    logic [3:0]  r_o_mon;
    logic [7:0]  r_o_year;

    logic [DIVISOR_W-1:0] divisor;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic [63:0]          mul_p;
    logic                 rem_over;
    logic                 after_feb;
    logic [5:0]           leaps;
    logic [15:0]          d68_next;
    logic [3:0]           m_dec;
    logic [8:0]           start_next;
    logic [8:0]           day_full;

    assign divisor = div_value(i_cmd.div);

    // one multiplier: reciprocal estimate, then quotient times divisor
    assign mul_a = i_cmd.mul ? r_num : r_prod[63:32];
    assign mul_b = i_cmd.mul ? div_recip(i_cmd.div) : {21'd0, divisor};
    assign mul_p = mul_a * mul_b;

    assign rem_over  = r_rem >= {21'd0, divisor};
    assign after_feb = r_rem[10:0] >= DAYS_TO_MARCH;
    assign leaps     = r_quo[5:0] + {5'd0, after_feb};
    assign d68_next  = r_quo[15:0] + DAYS_1968_TO_1970;

    assign m_dec      = r_m - 4'd1;
    assign start_next = MONTH_START[m_dec] + {8'd0, r_leap && (m_dec >= 4'd2)};
    assign day_full   = r_doy - r_start + 9'd1;

    assign o_stat.more     = (r_doy < r_start) && (r_m != 4'd0);
    assign o_stat.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= i_epoch_seconds;
        end
        if (i_cmd.mul) begin
            r_prod <= mul_p;
        end
        if (i_cmd.back) begin
            r_quo  <= r_prod[63:32];
            r_prod <= {32'd0, mul_p[31:0]};
        end
        if (i_cmd.sub) begin
            r_rem <= r_num - r_prod[31:0];
        end
        if (i_cmd.fix && rem_over) begin
            r_quo <= r_quo + 32'd1;
            r_rem <= r_rem - {21'd0, divisor};
        end
        if (i_cmd.store) begin
            case (i_cmd.div)
                DIV_SEC: begin
                    r_sec <= r_rem[5:0];
                    r_num <= r_quo;
                end
                DIV_MIN: begin
                    r_min <= r_rem[5:0];
                    r_num <= r_quo;
                end
                DIV_HR: begin
                    r_hr  <= r_rem[4:0];
                    r_d68 <= d68_next;
                    r_num <= {16'd0, d68_next};
                end
                DIV_PER: begin
                    r_prem <= r_rem[10:0];
                    r_num  <= {16'd0, r_d68 - {10'd0, leaps}};
                end
                DIV_YEAR: begin
                    r_year  <= r_quo[7:0] + BASE_YEAR;
                    r_leap  <= (r_quo[1:0] == 2'b00);
                    r_doy   <= r_rem[8:0] + {8'd0, (r_prem >= DAYS_TO_MARCH)
                               && (r_prem <= DAYS_PER_YEAR)};
                    r_m     <= MONTH_INIT;
                    r_start <= START_INIT;
                end
                default: begin
                    r_num <= r_quo;
                end
            endcase
        end
        if (i_cmd.mstep) begin
            r_m     <= m_dec;
            r_start <= start_next;
        end
        if (i_cmd.out_load) begin
            r_o_sec  <= r_sec;
            r_o_min  <= r_min;
            r_o_hr   <= r_hr;
            r_o_day  <= day_full[4:0];
            r_o_mon  <= r_m;
            r_o_year <= r_year;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_second_of_minute = r_o_sec;
    assign o_minute_of_hour   = r_o_min;
    assign o_hour_of_day      = r_o_hr;
    assign o_day_of_month     = r_o_day;
    assign o_month_index      = r_o_mon;
    assign o_years_since_1900 = r_o_year;

endmodule

[src/esc_checker.sv]
`timescale 1ns / 1ps

module esc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [31:0] i_epoch_seconds,
    input logic        o_valid,
    input logic        i_ready,
    input logic [5:0]  o_second_of_minute,
    input logic [5:0]  o_minute_of_hour,
    input logic [4:0]  o_hour_of_day,
    input logic [4:0]  o_day_of_month,
    input logic [3:0]  o_month_index,
    input logic [7:0]  o_years_since_1900
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_second_of_minute)
            && $stable(o_day_of_month) && $stable(o_years_since_1900))
        else $error("stalled result changed");

    // time of day stays in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_second_of_minute < 6'd60 && o_minute_of_hour < 6'd60
            && o_hour_of_day < 5'd24)
        else $error("time of day out of range");

    // date stays in range
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_day_of_month != 5'd0 && o_month_index < 4'd12
            && o_years_since_1900 >= 8'd70 && o_years_since_1900 <= 8'd206)
        else $error("date out of range");

    // one request at a time: busy right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted a request while busy");

    // no result appears right after acceptance of a request
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> !o_valid)
        else $error("result appeared too early");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);

[verif/epoch_seconds_to_calendar_tb.sv]
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;

    // Calendar fields at the widths of the result ports
    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] mday;
        logic [3:0] mon;
        logic [7:0] year;
    } calendar_t;

    // One directed request: typed rows carry their own expected calendar,
    // the others are checked against the predictor
    typedef struct packed {
        logic [31:0] secs;
        logic        typed;
        calendar_t   want;
    } stim_row_t;

    localparam int unsigned MONTH_FIRST_DAY [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    localparam int NUM_DIRECTED     = 22;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int PRESSURE_AT      = 1000;   // requests accepted before the stall
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 50;

    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        '{32'd0,          1'b1, '{6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 8'd70}},
        '{32'd59,         1'b0, '0},
        '{32'd60,         1'b0, '0},
        '{32'd3599,       1'b0, '0},
        '{32'd3600,       1'b0, '0},
        '{32'd86399,      1'b1, '{6'd59, 6'd59, 5'd23, 5'd1, 4'd0, 8'd70}},
        '{32'd86400,      1'b0, '0},
        '{32'd31535999,   1'b0, '0},   // last second of 1970
        '{32'd31536000,   1'b0, '0},
        '{32'd68169600,   1'b0, '0},   // leap day 1972
        '{32'd68256000,   1'b0, '0},
        '{32'd94608000,   1'b0, '0},   // last day of a leap year
        '{32'd951782400,  1'b0, '0},   // leap day 2000
        '{32'd951868800,  1'b0, '0},
        '{32'd2147483647, 1'b0, '0},
        '{32'd2147483648, 1'b0, '0},
        '{32'd4107542400, 1'b0, '0},   // 2100 treated as leap: its Feb 29
        '{32'd4107628800, 1'b0, '0},   // first day running behind the true calendar
        '{32'h55555555,   1'b0, '0},
        '{32'hAAAAAAAA,   1'b0, '0},
        '{32'hFFFFFFFE,   1'b0, '0},
        '{32'hFFFFFFFF,   1'b1, '{6'd15, 6'd28, 5'd6, 5'd6, 4'd1, 8'd206}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_epoch_seconds = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [5:0]  o_second_of_minute;
    logic [5:0]  o_minute_of_hour;
    logic [4:0]  o_hour_of_day;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month_index;
    logic [7:0]  o_years_since_1900;

    calendar_t pending_dates [$];
    int        send_idle_pct = 23;
    int        recv_idle_pct = 51;
    int        requests_sent = 0;
    int        requests_seen = 0;
    int        results_checked = 0;
    int        hold_left = 0;
    bit        pressure_done = 1'b0;
    int        errors = 0;

    epoch_seconds_to_calendar i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_day_of_month     (o_day_of_month),
        .o_month_index      (o_month_index),
        .o_years_since_1900 (o_years_since_1900)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predict the calendar date for a second count. Days are rebased to
    // 1968-01-01 so that each four-year period starts on a leap year; every
    // fourth year is leap, 2100 included.
    function automatic calendar_t calendar_of(input logic [31:0] secs);
        int unsigned mins, hours, days, d68, leaps, pos, yr, doy, year, m, start;
        bit          leap;
        calendar_t   c;
        mins   = secs / 60;
        hours  = mins / 60;
        days   = hours / 24;
        c.sec  = 6'(secs % 60);
        c.min  = 6'(mins % 60);
        c.hour = 5'(hours % 24);
        d68    = days + 731;
        leaps  = d68 / 1461;
        pos    = d68 % 1461;
        // count the leap day of this period once it is behind us
        if (pos >= 60)
            leaps++;
        yr  = (d68 - leaps) / 365;
        doy = d68 - yr * 365 - leaps;
        // inside the leap year itself, put the leap day back into day of year
        if (pos >= 60 && pos <= 365)
            doy++;
        year = yr + 68;
        leap = (year % 4) == 0;
        // step back from December to the last month starting on or before doy
        m     = 12;
        start = 366;
        while (doy < start && m > 0) begin
            m--;
            start = MONTH_FIRST_DAY[m];
            if (m >= 2 && leap)
                start++;
        end
        c.mday = 5'(doy - start + 1);
        c.mon  = 4'(m);
        c.year = 8'(year);
        return c;
    endfunction

    // Draw a request: whole-range values, plus day edges and the
    // leap-heavy stretches at the start and the end of the range
    function automatic logic [31:0] random_epoch();
        logic [31:0] day_start;
        logic [31:0] secs;
        day_start = 32'($urandom_range(49709)) * 32'd86400;
        case ($urandom_range(3))
            0: secs = $urandom;
            1: secs = day_start + ($urandom_range(1) ? 32'd0 : 32'd86399);
            2: secs = day_start + 32'($urandom_range(86399));
            default: begin
                if ($urandom_range(1))
                    secs = $urandom_range(94694400, 0);
                else
                    secs = $urandom_range(32'hFFFFFFFF, 32'd4102444800);
            end
        endcase
        return secs;
    endfunction

    // Offer one request after a random gap, hold it until accepted, then
    // queue the date it must produce
    task automatic send_request(input logic [31:0] secs, input logic typed,
                                input calendar_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_epoch_seconds <= secs;
        do @(posedge i_clk); while (!o_ready);
        pending_dates.push_back(typed ? want : calendar_of(secs));
        requests_sent++;
    endtask

    // Receiver: count accepted requests here and, once enough have gone in,
    // drop ready for a long stretch so the output register and the datapath
    // both fill and the block stalls its input
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            requests_seen <= requests_seen + 1;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!pressure_done && requests_seen >= PRESSURE_AT) begin
            pressure_done <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            i_ready       <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest queued date
    always @(posedge i_clk) begin
        calendar_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_dates.size() == 0) begin
                $error("result with no request waiting");
                errors++;
            end else begin
                want = pending_dates.pop_front();
                results_checked++;
                if (o_second_of_minute !== want.sec) begin
                    $error("second_of_minute: expected %0d, got %0d",
                           want.sec, o_second_of_minute);
                    errors++;
                end
                if (o_minute_of_hour !== want.min) begin
                    $error("minute_of_hour: expected %0d, got %0d",
                           want.min, o_minute_of_hour);
                    errors++;
                end
                if (o_hour_of_day !== want.hour) begin
                    $error("hour_of_day: expected %0d, got %0d",
                           want.hour, o_hour_of_day);
                    errors++;
                end
                if (o_day_of_month !== want.mday) begin
                    $error("day_of_month: expected %0d, got %0d",
                           want.mday, o_day_of_month);
                    errors++;
                end
                if (o_month_index !== want.mon) begin
                    $error("month_index: expected %0d, got %0d",
                           want.mon, o_month_index);
                    errors++;
                end
                if (o_years_since_1900 !== want.year) begin
                    $error("years_since_1900: expected %0d, got %0d",
                           want.year, o_years_since_1900);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the first idle mix
        foreach (DIRECTED[k])
            send_request(DIRECTED[k].secs, DIRECTED[k].typed, DIRECTED[k].want);

        // Random requests: receiver sparse, then sender sparse, then neither
        // idles; the long output stall lands in the last phase
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 23; recv_idle_pct = 51; end
                1: begin send_idle_pct = 51; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            repeat (RANDOM_PER_PHASE)
                send_request(random_epoch(), 1'b0, '0);
        end
        i_valid <= 1'b0;

        // Drain, then give a stray result time to show up
        while (pending_dates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d requests (%0d directed, %0d random), %0d results checked.",
                 requests_sent, NUM_DIRECTED, requests_sent - NUM_DIRECTED,
                 results_checked);
        $display("Idle mixes 23/51, 51/23 and none, one %0d-cycle output stall, %0d errors.",
                 HOLD_CYCLES, errors);
        if (errors == 0)
            $display("epoch_seconds_to_calendar_tb: PASS");
        else
            $display("epoch_seconds_to_calendar_tb: FAIL");
        $finish;
    end

    // Abort a hung run
    initial begin
        #5_000_000;
        $display("epoch_seconds_to_calendar_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
src/esc_pkg.sv
src/esc_ctrl.sv
src/esc_dpath.sv
src/epoch_seconds_to_calendar.sv
src/esc_checker.sv
verif/epoch_seconds_to_calendar_tb.sv
